>>> rtl/square_fourier_sum_smoother_unit_macros.svh
// assertion macros for the square wave smoother checker
// no dependencies; included by the checker file only
`ifndef SQUARE_FOURIER_SUM_SMOOTHER_UNIT_MACROS_SVH
`define SQUARE_FOURIER_SUM_SMOOTHER_UNIT_MACROS_SVH

// property checked only while out of reset
`define SFSS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define SFSS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sfss_pkg.sv
// shared types, constants and the quarter-wave sine rom for the square wave smoother
// no dependencies
`default_nettype none

package sfss_pkg;

  localparam int OVERSAMPLE    = 16;
  localparam int MAX_HARMONICS = 256;
  localparam int SINE_DEPTH    = 1024;

  localparam int TAPS   = 2 * OVERSAMPLE - 1;
  localparam int TAP_W  = $clog2(TAPS);
  localparam int WGT_W  = $clog2(OVERSAMPLE + 1);
  localparam int HARM_W = $clog2(MAX_HARMONICS);

  localparam int CNT_W  = 9;
  localparam int PH_W   = 32;
  localparam int GAIN_W = 10;
  localparam int BASE_W = 12;
  localparam int COL_W  = 12;
  localparam int LVL_W  = 16;
  localparam int SCR_W  = 16;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // sine lookup
  localparam int SINE_W    = 15;
  localparam int IDX_W     = $clog2(SINE_DEPTH) + 1;
  localparam int IDX_SHIFT = 30 - $clog2(SINE_DEPTH);

  localparam longint unsigned HALF_PI_Q30      = 64'd1686629713;
  localparam longint unsigned FOUR_OVER_PI_Q24 = 64'd21361415;

  // divide by odd harmonic: k/m = qk + rk/m, rk/m by reciprocal
  localparam int QK_W      = 25;
  localparam int RK_W      = $clog2(2 * MAX_HARMONICS);
  localparam int RCP_W     = 32;
  localparam int RCP_SHIFT = 32;
  localparam int X_W       = SINE_W + RK_W;
  localparam int QA_W      = SINE_W + QK_W;
  localparam int TERM_W    = QA_W + 1;
  localparam int WT_W      = TERM_W + WGT_W + 1;
  localparam int ACC_W     = 56;
  localparam int LVL_SHIFT = 24 + 2 * $clog2(OVERSAMPLE);

  // cycles from the last issued term until the output stage holds the result
  localparam int DRAIN_LEN = 8;
  localparam int DRAIN_W   = $clog2(DRAIN_LEN);

  localparam logic [CNT_W-1:0]  RST_HARMONIC_COUNT  = 9'd1;
  localparam logic [PH_W-1:0]   RST_PHASE_START     = 32'd858993459;
  localparam logic [PH_W-1:0]   RST_PHASE_INCREMENT = 32'd433411;
  localparam logic [GAIN_W-1:0] RST_AMPLITUDE_GAIN  = 10'd120;
  localparam logic [BASE_W-1:0] RST_BASELINE_OFFSET = 12'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HARMONIC_COUNT  = 3'd0,
    REG_PHASE_START     = 3'd1,
    REG_PHASE_INCREMENT = 3'd2,
    REG_AMPLITUDE_GAIN  = 3'd3,
    REG_BASELINE_OFFSET = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  harmonic_count;
    logic [PH_W-1:0]   phase_start;
    logic [PH_W-1:0]   phase_increment;
    logic [GAIN_W-1:0] amplitude_gain;
    logic [BASE_W-1:0] baseline_offset;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic              capture;
    logic              load;
    logic              issue;
    logic              last_harm;
    logic [HARM_W-1:0] harm;
    logic [WGT_W-1:0]  weight;
    logic              publish;
  } dp_cmd_t;

  typedef logic [SINE_DEPTH:0][SINE_W-1:0] sine_rom_t;

  localparam longint unsigned TAYLOR_DEN [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // taylor series through x^17, angle in q30, rounded to q14
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    rom = '0;
    for (int t = 0; t <= SINE_DEPTH; t++) begin
      x    = (64'(t) * HALF_PI_Q30) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DEN[n-1];
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      rom[t] = SINE_W'((sum + 64'sd32768) >>> 16);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

>>> rtl/sfss_cfg_regs.sv
// configuration register file of the square wave smoother
// depends on sfss_pkg
`default_nettype none

module sfss_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sfss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sfss_pkg::cfg_t                   cfg
);
  import sfss_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HARMONIC_COUNT:  cfg_nxt.harmonic_count  = cfg_wdata[CNT_W-1:0];
        REG_PHASE_START:     cfg_nxt.phase_start     = cfg_wdata[PH_W-1:0];
        REG_PHASE_INCREMENT: cfg_nxt.phase_increment = cfg_wdata[PH_W-1:0];
        REG_AMPLITUDE_GAIN:  cfg_nxt.amplitude_gain  = cfg_wdata[GAIN_W-1:0];
        REG_BASELINE_OFFSET: cfg_nxt.baseline_offset = cfg_wdata[BASE_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.harmonic_count  <= RST_HARMONIC_COUNT;
      cfg_r.phase_start     <= RST_PHASE_START;
      cfg_r.phase_increment <= RST_PHASE_INCREMENT;
      cfg_r.amplitude_gain  <= RST_AMPLITUDE_GAIN;
      cfg_r.baseline_offset <= RST_BASELINE_OFFSET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/sfss_ctrl.sv
// sequencer of the square wave smoother: walks taps and harmonics, drains, hands off
// depends on sfss_pkg
`default_nettype none

module sfss_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sfss_pkg::CNT_W-1:0]    harmonic_count,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output sfss_pkg::dp_cmd_t             cmd
);
  import sfss_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } ctrl_state_t;

  ctrl_state_t        state_r, state_nxt;
  logic [TAP_W-1:0]   tap_r, tap_nxt;
  logic [HARM_W-1:0]  harm_r, harm_nxt;
  logic [DRAIN_W-1:0] drain_r, drain_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]   count_eff;
  logic               last_harm;
  logic               last_tap;
  logic [WGT_W-1:0]   weight;
  logic               out_free;

  assign count_eff = (harmonic_count > CNT_W'(MAX_HARMONICS)) ?
                     CNT_W'(MAX_HARMONICS) : harmonic_count;
  assign last_harm = (CNT_W'(harm_r) == count_eff - CNT_W'(1));
  assign last_tap  = (tap_r == TAP_W'(TAPS - 1));
  // triangular weight oversample - |k|, k = tap - (oversample - 1)
  assign weight    = (tap_r < TAP_W'(OVERSAMPLE - 1)) ?
                     WGT_W'(tap_r + TAP_W'(1)) : WGT_W'(TAP_W'(TAPS) - tap_r);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    harm_nxt      = harm_r;
    drain_nxt     = drain_r;
    cmd           = '0;
    cmd.harm      = harm_r;
    cmd.weight    = weight;
    cmd.last_harm = last_harm;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        tap_nxt   = '0;
        harm_nxt  = '0;
        drain_nxt = '0;
        state_nxt = (count_eff == '0) ? ST_DRAIN : ST_RUN;
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (last_harm) begin
          harm_nxt = '0;
          if (last_tap) begin
            state_nxt = ST_DRAIN;
          end else begin
            tap_nxt = tap_r + TAP_W'(1);
          end
        end else begin
          harm_nxt = harm_r + HARM_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_r == DRAIN_W'(DRAIN_LEN - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          drain_nxt = drain_r + DRAIN_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= '0;
      harm_r      <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      harm_r      <= harm_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/sfss_datapath.sv
// phase generation, sine rom, harmonic divide, weighted accumulate and output scaling
// depends on sfss_pkg
`default_nettype none

module sfss_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sfss_pkg::dp_cmd_t                  cmd,
  input  sfss_pkg::cfg_t                     cfg,
  input  logic signed [sfss_pkg::COL_W-1:0]  column,
  output logic signed [sfss_pkg::LVL_W-1:0]  level,
  output logic signed [sfss_pkg::SCR_W-1:0]  screen_y
);
  import sfss_pkg::*;

  localparam int J_W        = COL_W + $clog2(OVERSAMPLE) + 1;
  localparam int LVL_MAG_W  = ACC_W - LVL_SHIFT + 1;
  localparam int PROD_W     = GAIN_W + 1 + LVL_W;
  localparam int PRND_SHIFT = 10;
  localparam int PMAG_W     = PROD_W + 1 - PRND_SHIFT;
  localparam int SUM_W      = SCR_W + 4;

  localparam logic [ACC_W:0]  LVL_HALF  = (ACC_W + 1)'(1) << (LVL_SHIFT - 1);
  localparam logic [PROD_W:0] PRND_HALF = (PROD_W + 1)'(1) << (PRND_SHIFT - 1);

  // per-harmonic divide constants
  logic [QK_W-1:0]  qk_tab  [MAX_HARMONICS];
  logic [RK_W-1:0]  rk_tab  [MAX_HARMONICS];
  logic [RCP_W-1:0] rcp_tab [MAX_HARMONICS];

  for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_recip
    localparam longint unsigned M        = 64'(2 * g + 1);
    localparam logic [QK_W-1:0] QK       = QK_W'(FOUR_OVER_PI_Q24 / M);
    localparam logic [RK_W-1:0] RK       = RK_W'(FOUR_OVER_PI_Q24 % M);
    localparam longint unsigned RCP_FULL = ((64'd1 << RCP_SHIFT) + M - 64'd1) / M;
    // first harmonic has no remainder, so its reciprocal is never used
    localparam logic [RCP_W-1:0] RCP     = (g == 0) ? '0 : RCP_W'(RCP_FULL);
    assign qk_tab[g]  = QK;
    assign rk_tab[g]  = RK;
    assign rcp_tab[g] = RCP;
  end

  // phase generation
  logic signed [COL_W-1:0] col_r;
  logic [PH_W-1:0]         base_r;
  logic [PH_W-1:0]         harm_ph_r;
  logic signed [J_W-1:0]   j0;
  logic [PH_W-1:0]         jx;
  logic [PH_W-1:0]         base0;
  logic [PH_W-1:0]         base_step;

  assign j0        = (J_W'(col_r) <<< $clog2(OVERSAMPLE)) - J_W'(OVERSAMPLE - 1);
  assign jx        = PH_W'(j0);
  assign base0     = cfg.phase_start + jx * cfg.phase_increment;
  assign base_step = base_r + cfg.phase_increment;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r <= column;
    end
    if (cmd.load) begin
      base_r    <= base0;
      harm_ph_r <= base0;
    end else if (cmd.issue) begin
      if (cmd.last_harm) begin
        base_r    <= base_step;
        harm_ph_r <= base_step;
      end else begin
        // next odd harmonic: phase advances by twice the base phase
        harm_ph_r <= harm_ph_r + {base_r[PH_W-2:0], 1'b0};
      end
    end
  end

  // stage 1: sine rom
  logic [30:0]       frac_rnd;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  rom_idx;

  assign frac_rnd = {1'b0, harm_ph_r[29:0]} + (31'(1) << (IDX_SHIFT - 1));
  assign idx      = frac_rnd[30:IDX_SHIFT];
  assign rom_idx  = harm_ph_r[30] ? (IDX_W'(SINE_DEPTH) - idx) : idx;

  logic              s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [SINE_W-1:0] s1_mag_r;
  logic              s1_neg_r, s2_neg_r, s3_neg_r;
  logic [HARM_W-1:0] s1_harm_r, s2_harm_r;
  logic [WGT_W-1:0]  s1_wgt_r, s2_wgt_r, s3_wgt_r, s4_wgt_r;
  logic [X_W-1:0]    s2_x_r;
  logic [QA_W-1:0]   s2_qa_r, s3_qa_r;
  logic [X_W-1:0]    s3_qb_r;
  logic signed [TERM_W-1:0] s4_term_r;
  logic signed [WT_W-1:0]   s5_wt_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic [X_W+RCP_W-1:0]     qb_prod;
  logic [QA_W-1:0]          term_mag;
  logic signed [TERM_W-1:0] term;

  assign qb_prod  = s2_x_r * rcp_tab[s2_harm_r];
  assign term_mag = s3_qa_r + QA_W'(s3_qb_r);
  assign term     = s3_neg_r ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    s1_mag_r  <= SINE_ROM[rom_idx];
    s1_neg_r  <= harm_ph_r[31];
    s1_harm_r <= cmd.harm;
    s1_wgt_r  <= cmd.weight;
    // stage 2: integer part and remainder part of s*k/m
    s2_x_r    <= X_W'(s1_mag_r * rk_tab[s1_harm_r]);
    s2_qa_r   <= QA_W'(s1_mag_r * qk_tab[s1_harm_r]);
    s2_neg_r  <= s1_neg_r;
    s2_harm_r <= s1_harm_r;
    s2_wgt_r  <= s1_wgt_r;
    // stage 3: remainder divided by m through its reciprocal
    s3_qb_r   <= qb_prod[X_W+RCP_W-1:RCP_SHIFT];
    s3_qa_r   <= s2_qa_r;
    s3_neg_r  <= s2_neg_r;
    s3_wgt_r  <= s2_wgt_r;
    // stage 4: signed term, truncated toward zero
    s4_term_r <= term;
    s4_wgt_r  <= s3_wgt_r;
    // stage 5: tap weight
    s5_wt_r   <= s4_term_r * $signed({1'b0, s4_wgt_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
    end else if (s5_v_r) begin
      acc_r <= acc_r + ACC_W'(s5_wt_r);
    end
  end

  // level: round half away from zero, saturate
  logic [ACC_W-1:0]     acc_mag;
  logic [ACC_W:0]       acc_rnd;
  logic [LVL_MAG_W-1:0] lvl_mag;
  logic signed [LVL_W-1:0] level_nxt;
  logic signed [LVL_W-1:0] level_r;

  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign acc_rnd = {1'b0, acc_mag} + LVL_HALF;
  assign lvl_mag = acc_rnd[ACC_W:LVL_SHIFT];

  always_comb begin
    if (acc_r[ACC_W-1]) begin
      if (lvl_mag > LVL_MAG_W'(32768)) begin
        level_nxt = LVL_W'(-32768);
      end else begin
        level_nxt = -$signed(LVL_W'(lvl_mag));
      end
    end else begin
      if (lvl_mag > LVL_MAG_W'(32767)) begin
        level_nxt = LVL_W'(32767);
      end else begin
        level_nxt = $signed(LVL_W'(lvl_mag));
      end
    end
  end

  // screen position
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        pmag;
  logic [PROD_W:0]          prnd;
  logic [PMAG_W-1:0]        pq;
  logic signed [SUM_W-1:0]  base16;
  logic signed [SUM_W-1:0]  scr_sum;
  logic signed [SCR_W-1:0]  screen_nxt;
  logic signed [SCR_W-1:0]  screen_r;

  assign pmag    = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign prnd    = {1'b0, pmag} + PRND_HALF;
  assign pq      = prnd[PROD_W:PRND_SHIFT];
  assign base16  = $signed(SUM_W'({cfg.baseline_offset, 4'b0000}));
  assign scr_sum = prod_r[PROD_W-1] ? (base16 - $signed(SUM_W'(pq)))
                                    : (base16 + $signed(SUM_W'(pq)));

  always_comb begin
    if (scr_sum > SUM_W'(32767)) begin
      screen_nxt = SCR_W'(32767);
    end else if (scr_sum < -$signed(SUM_W'(32768))) begin
      screen_nxt = SCR_W'(-32768);
    end else begin
      screen_nxt = SCR_W'(scr_sum);
    end
  end

  logic signed [LVL_W-1:0] out_level_r;
  logic signed [SCR_W-1:0] out_screen_r;

  always_ff @(posedge clk) begin
    level_r  <= level_nxt;
    prod_r   <= $signed({1'b0, cfg.amplitude_gain}) * level_r;
    screen_r <= screen_nxt;
    if (cmd.publish) begin
      out_level_r  <= level_r;
      out_screen_r <= screen_r;
    end
  end

  assign level    = out_level_r;
  assign screen_y = out_screen_r;

endmodule

`default_nettype wire

>>> rtl/square_fourier_sum_smoother_unit.sv
// square wave partial fourier sum smoother, top level; uses sfss_pkg and its submodules
// one item in flight: the next input is taken once the last result is published
// harmonic count capped at 256; one harmonic term per cycle on the shared
//   sine rom / divide / accumulate pipeline, 2*16-1 oversampled taps per item
// reset: rst_n synchronous active low, registers back to defaults, pipeline and output emptied
`default_nettype none

module square_fourier_sum_smoother_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sfss_pkg::IN_DATA_W-1:0]    in_tdata,   // [11:0] column
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sfss_pkg::OUT_DATA_W-1:0]   out_tdata,  // [15:0] level, [31:16] screen_y
  input  logic                              cfg_we,
  input  logic [sfss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfss_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sfss_pkg::*;

  cfg_t                    cfg;
  dp_cmd_t                 cmd;
  logic signed [LVL_W-1:0] level;
  logic signed [SCR_W-1:0] screen_y;

  sfss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sfss_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .harmonic_count (cfg.harmonic_count),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .cmd            (cmd)
  );

  sfss_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .column   ($signed(in_tdata[COL_W-1:0])),
    .level    (level),
    .screen_y (screen_y)
  );

  assign out_tdata = {screen_y, level};

endmodule

`default_nettype wire

>>> rtl/sfss_checker.sv
// port-level checks for the square wave smoother, bound to the top level
// depends on sfss_pkg and square_fourier_sum_smoother_unit_macros.svh
`default_nettype none
`include "square_fourier_sum_smoother_unit_macros.svh"

module sfss_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sfss_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import sfss_pkg::*;

  // reset empties the output register
  `SFSS_ASSERT_ALWAYS(a_rst_out_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // one item in flight: busy right after an input transfer
  `SFSS_ASSERT(a_busy_after_in, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready,
    "input ready right after a transfer")

  // a new result only appears at the end of a busy phase
  `SFSS_ASSERT(a_result_from_busy, clk, rst_n, $rose(out_tvalid) |-> $past(!in_tready),
    "result appeared while idle")

  // a stalled result holds
  `SFSS_ASSERT(a_out_hold, clk, rst_n,
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)),
    "stalled result changed")

endmodule

bind square_fourier_sum_smoother_unit sfss_checker u_sfss_checker (.*);

`default_nettype wire
